### rtl/core/mbup_pkg.sv
package mbup_pkg;

  localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
  localparam logic [7:0] STATUS_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] STATUS_SONG_POS    = 8'hF2;
  localparam logic [7:0] STATUS_SONG_SEL    = 8'hF3;
  localparam logic [7:0] STATUS_SYSEX_END   = 8'hF7;
  localparam logic [7:0] STATUS_META        = 8'hFF;

  localparam logic [3:0] NIBBLE_SYSTEM      = 4'hF;
  localparam logic [3:0] NIBBLE_PROG_CHANGE = 4'hC;
  localparam logic [3:0] NIBBLE_CHAN_PRESS  = 4'hD;

  localparam logic [3:0] CIN_SYSEX_MID  = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  localparam logic [1:0] POS_NONE  = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;
  localparam logic [1:0] CNT_SYSEX = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] expected_data_count;
    logic [1:0] data_position;
    logic [7:0] held_first_data;
    logic [7:0] held_second_data;
  } mbup_ctx_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
  } mbup_pkt_t;

endpackage

### rtl/core/mbup_core.sv
module mbup_core
  import mbup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  output logic       pkt_valid,
  output mbup_pkt_t  pkt
);

  mbup_ctx_t ctx_r;
  mbup_ctx_t ctx_nxt;

  always_comb begin
    ctx_nxt   = ctx_r;
    pkt_valid = 1'b0;
    pkt       = '0;
    if (data_byte[7]) begin
      if (data_byte[7:4] != NIBBLE_SYSTEM) begin
        ctx_nxt.running_status      = data_byte;
        ctx_nxt.expected_data_count =
          (data_byte[7:4] == NIBBLE_PROG_CHANGE || data_byte[7:4] == NIBBLE_CHAN_PRESS)
          ? CNT_ONE : CNT_TWO;
        ctx_nxt.data_position       = POS_NONE;
      end else begin
        case (data_byte)
          STATUS_MTC_QFRAME, STATUS_SONG_SEL: begin
            ctx_nxt.running_status      = data_byte;
            ctx_nxt.expected_data_count = CNT_ONE;
            ctx_nxt.data_position       = POS_NONE;
          end
          STATUS_SONG_POS, STATUS_META: begin
            ctx_nxt.running_status      = data_byte;
            ctx_nxt.expected_data_count = CNT_TWO;
            ctx_nxt.data_position       = POS_NONE;
          end
          STATUS_SYSEX_START: begin
            ctx_nxt.expected_data_count = CNT_SYSEX;
            ctx_nxt.held_first_data     = STATUS_SYSEX_START;
            ctx_nxt.data_position       = POS_ONE;
          end
          STATUS_SYSEX_END: begin
            case (ctx_r.data_position)
              POS_NONE: begin
                pkt_valid = 1'b1;
                pkt = '{CIN_SYSEX_END1, STATUS_SYSEX_END, 8'h00, 8'h00};
              end
              POS_ONE: begin
                pkt_valid = 1'b1;
                pkt = '{CIN_SYSEX_END2, ctx_r.held_first_data, STATUS_SYSEX_END, 8'h00};
              end
              POS_TWO: begin
                pkt_valid = 1'b1;
                pkt = '{CIN_SYSEX_END3, ctx_r.held_first_data, ctx_r.held_second_data,
                        STATUS_SYSEX_END};
              end
              default: ;
            endcase
          end
          default: begin
            pkt_valid = 1'b1;
            pkt = '{CIN_SINGLE, data_byte, 8'h00, 8'h00};
          end
        endcase
      end
    end else begin
      case (ctx_r.data_position)
        POS_NONE: begin
          ctx_nxt.held_first_data = data_byte;
          if (ctx_r.expected_data_count == CNT_ONE) begin
            pkt_valid = 1'b1;
            pkt = '{ctx_r.running_status[7:4], ctx_r.running_status, data_byte, 8'h00};
          end else begin
            ctx_nxt.data_position = POS_ONE;
          end
        end
        POS_ONE: begin
          ctx_nxt.held_second_data = data_byte;
          if (ctx_r.expected_data_count == CNT_TWO) begin
            ctx_nxt.data_position = POS_NONE;
            pkt_valid = 1'b1;
            pkt = '{ctx_r.running_status[7:4], ctx_r.running_status,
                    ctx_r.held_first_data, data_byte};
          end else begin
            ctx_nxt.data_position = POS_TWO;
          end
        end
        POS_TWO: begin
          ctx_nxt.data_position = POS_NONE;
          pkt_valid = 1'b1;
          pkt = '{CIN_SYSEX_MID, ctx_r.held_first_data, ctx_r.held_second_data, data_byte};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (step) begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

### rtl/core/mbup_out_reg.sv
module mbup_out_reg
  import mbup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  mbup_pkt_t  pkt_in,
  output logic       free,
  input  logic       out_ready,
  output logic       out_valid,
  output mbup_pkt_t  pkt_out
);

  logic      valid_r;
  mbup_pkt_t pkt_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign pkt_out   = pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_r <= pkt_in;
    end
  end

endmodule

### rtl/core/midi_byte_to_usb_event_packer.sv
// an accepted byte passes through the input register, then the result register, before its packet shows
// throughput: one byte per cycle; a pending packet stalls the input only if out_ready is low
// bytes that produce no packet (data still collecting, status latch) never wait on out_ready
// reset: rst_n synchronous active low; clears running status, data count, position,
// held bytes and both valid flags
module midi_byte_to_usb_event_packer
  import mbup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_code_index,
  output logic [7:0] out_byte_zero,
  output logic [7:0] out_byte_one,
  output logic [7:0] out_byte_two
);

  // input register stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // decode results for the byte sitting in the input register
  logic      pkt_valid;
  mbup_pkt_t pkt;
  mbup_pkt_t pkt_q;
  logic      out_free;
  logic      advance;

  // the held byte moves on when it has no packet, or the result reg can take one
  assign advance  = in_valid_r && (!pkt_valid || out_free);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  // state update and packet build, committed only when the byte advances
  mbup_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  // result register; frees itself in the same cycle the sink takes a transaction
  mbup_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && pkt_valid),
    .pkt_in    (pkt),
    .free      (out_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pkt_out   (pkt_q)
  );

  assign out_code_index = pkt_q.code_index;
  assign out_byte_zero  = pkt_q.byte_zero;
  assign out_byte_one   = pkt_q.byte_one;
  assign out_byte_two   = pkt_q.byte_two;

endmodule

### rtl/core/mbup_checker.sv
module mbup_checker
  import mbup_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_code_index,
  input logic [7:0] out_byte_zero,
  input logic [7:0] out_byte_one,
  input logic [7:0] out_byte_two
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_index) &&
    $stable(out_byte_zero) && $stable(out_byte_one) && $stable(out_byte_two))
    else $error("stalled result changed");

  // no result directly out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result needs an earlier input transaction, taken through the input register and then the result register
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without input transaction");

  // sysex end packets carry the end marker in the right slot
  a_sysex_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_code_index != CIN_SYSEX_END1 ||
        (out_byte_zero == STATUS_SYSEX_END && out_byte_one == 8'h00 && out_byte_two == 8'h00)) &&
      (out_code_index != CIN_SYSEX_END2 ||
        (out_byte_one == STATUS_SYSEX_END && out_byte_two == 8'h00)) &&
      (out_code_index != CIN_SYSEX_END3 || out_byte_two == STATUS_SYSEX_END))
    else $error("sysex end packet malformed");

  // a sysex middle packet ends in a data byte
  a_sysex_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_index == CIN_SYSEX_MID |-> !out_byte_two[7])
    else $error("sysex middle packet ends in status byte");

endmodule

bind midi_byte_to_usb_event_packer mbup_checker u_mbup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_index (out_code_index),
  .out_byte_zero  (out_byte_zero),
  .out_byte_one   (out_byte_one),
  .out_byte_two   (out_byte_two)
);
